[hw/rtl/biq_pkg.sv]
// Shared types and constants of the biquad IIR filter.
// Depends on nothing; used by the top level.
package biq_pkg;

   // Fraction bits of the stored output and of the coefficients.
   localparam int STORE_FRAC = 8;
   localparam int COEF_FRAC  = 14;
   // Width of the stored (unscaled) output.
   localparam int Y_WIDTH    = 32;
   // Width of the register index on the configuration port.
   localparam int CSR_IDX_W  = 3;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_B0   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B1   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B2   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A0   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_A1   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_A2   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN = 3'd6;

   // Product terms of the accumulation, in the order they are summed.
   localparam logic [2:0] TERM_B0 = 3'd0;
   localparam logic [2:0] TERM_B1 = 3'd1;
   localparam logic [2:0] TERM_B2 = 3'd2;
   localparam logic [2:0] TERM_A1 = 3'd3;
   localparam logic [2:0] TERM_A2 = 3'd4;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_MUL  = 7'b0000010,
      ST_PREP = 7'b0000100,
      ST_DIV  = 7'b0001000,
      ST_SAT  = 7'b0010000,
      ST_GAIN = 7'b0100000,
      ST_FIN  = 7'b1000000
   } state_type;

endpackage

[hw/rtl/biquad_iir_filter.sv]
// The datapath is one bit-serial shift-add unit and one restoring divider, one bit per cycle
// each. The block works on one item at a time: the next item is taken once the previous one
// has left the sequencer.
// Reset (synchronous, active high) clears the history, the sequencer and the output valid,
// and loads the coefficient reset values.
// Biquad IIR section, direct form I, fixed point, bit-serial datapath.
// Depends on biq_pkg.
module biquad_iir_filter #(
   parameter int SAMPLE_WIDTH = 16,
   parameter int COEF_WIDTH   = 18
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]         req_sample_in,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]         rsp_sample_out,
   output logic                                   rsp_clipped,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [biq_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [COEF_WIDTH-1:0]                  csr_data
);

   localparam int FF_W   = SAMPLE_WIDTH + biq_pkg::STORE_FRAC;
   localparam int PROD_W = (FF_W > biq_pkg::Y_WIDTH) ? FF_W : biq_pkg::Y_WIDTH;
   localparam int ACC_W  = COEF_WIDTH + PROD_W + 3;
   localparam int CNT_W  = $clog2(ACC_W + 1);
   localparam int A0_W   = COEF_WIDTH - 1;
   localparam int SHIFT  = biq_pkg::STORE_FRAC + biq_pkg::COEF_FRAC;
   localparam int YW     = biq_pkg::Y_WIDTH;

   localparam logic signed [ACC_W-1:0] S_HI = ACC_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
   localparam logic signed [ACC_W-1:0] S_LO = -S_HI - ACC_W'(1);
   localparam logic [ACC_W-1:0] Y_POS = ACC_W'((64'd1 << (YW - 1)) - 64'd1);
   localparam logic [ACC_W-1:0] Y_NEG = ACC_W'(64'd1 << (YW - 1));
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(64'sd1 <<< (SHIFT - 1));

   // Coefficient registers.
   logic signed [COEF_WIDTH-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff, gain_ff;
   logic [A0_W-1:0]              a0_ff;

   // History.
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x1_ff, x2_ff;
   logic signed [YW-1:0]           y1_ff, y2_ff;

   // Sequencer and datapath.
   biq_pkg::state_type state_ff, state_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic [YW-1:0]           mplier_ff, mplier_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [2:0]              term_ff, term_in;
   logic [A0_W-1:0]         rem_ff, rem_in;
   logic                    neg_ff, neg_in;
   logic                    zero_ff, zero_in;
   logic                    clip_ff, clip_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_clip_ff, rsp_clip_in;

   // Operand selection for the start of a product term.
   logic [2:0]              term_sel;
   logic signed [ACC_W-1:0] ld_mc;
   logic [YW-1:0]           ld_md;

   logic                    last_bit;
   logic signed [ACC_W-1:0] addend, mac_sum;
   logic [A0_W:0]           rem_sh;
   logic                    q_bit;
   logic signed [YW-1:0]    y_val;
   logic                    y_clip;
   logic signed [ACC_W-1:0] s_val;
   logic                    out_free;

   assign req_ready      = (state_ff == biq_pkg::ST_IDLE);
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_clipped    = rsp_clip_ff;
   assign out_free       = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ld_mc = '0;
      ld_md = '0;
      unique case (term_sel)
         biq_pkg::TERM_B0: begin
            ld_mc = ACC_W'(b0_ff) <<< biq_pkg::STORE_FRAC;
            ld_md = YW'(x_ff);
         end
         biq_pkg::TERM_B1: begin
            ld_mc = ACC_W'(b1_ff) <<< biq_pkg::STORE_FRAC;
            ld_md = YW'(x1_ff);
         end
         biq_pkg::TERM_B2: begin
            ld_mc = ACC_W'(b2_ff) <<< biq_pkg::STORE_FRAC;
            ld_md = YW'(x2_ff);
         end
         biq_pkg::TERM_A1: begin
            ld_mc = -ACC_W'(a1_ff);
            ld_md = y1_ff;
         end
         biq_pkg::TERM_A2: begin
            ld_mc = -ACC_W'(a2_ff);
            ld_md = y2_ff;
         end
         default: begin
            ld_mc = '0;
            ld_md = '0;
         end
      endcase
   end

   // The multiplier's top bit carries negative weight, so the last step subtracts.
   always_comb begin
      if ((state_ff == biq_pkg::ST_MUL) && (term_ff <= biq_pkg::TERM_B2)) begin
         last_bit = (cnt_ff == CNT_W'(SAMPLE_WIDTH - 1));
      end else begin
         last_bit = (cnt_ff == CNT_W'(YW - 1));
      end
      addend  = mplier_ff[0] ? mcand_ff : '0;
      mac_sum = last_bit ? (acc_ff - addend) : (acc_ff + addend);
   end

   // Restoring division step on the magnitude held in the accumulator.
   always_comb begin
      rem_sh = {rem_ff, acc_ff[ACC_W-1]};
      q_bit  = (rem_sh >= {1'b0, a0_ff});
   end

   // Quotient to stored output, saturated to 32 bits. A zero divisor yields an
   // all-ones quotient, which saturates by sign, unless the sum itself was zero.
   always_comb begin
      y_clip = 1'b0;
      if (zero_ff) begin
         y_val = '0;
      end else if (!neg_ff) begin
         if (acc_ff > Y_POS) begin
            y_val  = YW'(Y_POS);
            y_clip = 1'b1;
         end else begin
            y_val = acc_ff[YW-1:0];
         end
      end else begin
         if (acc_ff > Y_NEG) begin
            y_val  = YW'(Y_NEG);
            y_clip = 1'b1;
         end else begin
            y_val = -acc_ff[YW-1:0];
         end
      end
   end

   assign s_val = acc_ff >>> SHIFT;

   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      cnt_in        = cnt_ff;
      term_in       = term_ff;
      rem_in        = rem_ff;
      neg_in        = neg_ff;
      zero_in       = zero_ff;
      clip_in       = clip_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_clip_in   = rsp_clip_ff;
      term_sel      = biq_pkg::TERM_B0;

      unique case (state_ff)
         biq_pkg::ST_IDLE: begin
            term_sel = biq_pkg::TERM_B0;
            if (req_valid) begin
               acc_in   = '0;
               term_in  = biq_pkg::TERM_B0;
               cnt_in   = '0;
               clip_in  = 1'b0;
               // The sample itself is still on the port in this cycle.
               mcand_in  = ACC_W'(b0_ff) <<< biq_pkg::STORE_FRAC;
               mplier_in = YW'(req_sample_in);
               state_in  = biq_pkg::ST_MUL;
            end
         end
         biq_pkg::ST_MUL: begin
            term_sel  = term_ff + 3'd1;
            acc_in    = mac_sum;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (last_bit) begin
               cnt_in = '0;
               if (term_ff == biq_pkg::TERM_A2) begin
                  state_in = biq_pkg::ST_PREP;
               end else begin
                  term_in   = term_sel;
                  mcand_in  = ld_mc;
                  mplier_in = ld_md;
               end
            end
         end
         biq_pkg::ST_PREP: begin
            neg_in  = acc_ff[ACC_W-1];
            zero_in = (acc_ff == '0);
            acc_in  = acc_ff[ACC_W-1] ? -acc_ff : acc_ff;
            rem_in  = '0;
            cnt_in  = '0;
            state_in = biq_pkg::ST_DIV;
         end
         biq_pkg::ST_DIV: begin
            rem_in = q_bit ? A0_W'(rem_sh - {1'b0, a0_ff}) : rem_sh[A0_W-1:0];
            acc_in = {acc_ff[ACC_W-2:0], q_bit};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(ACC_W - 1)) begin
               state_in = biq_pkg::ST_SAT;
            end
         end
         biq_pkg::ST_SAT: begin
            clip_in   = y_clip;
            acc_in    = ROUND_HALF;
            mcand_in  = ACC_W'(gain_ff);
            mplier_in = y_val;
            cnt_in    = '0;
            state_in  = biq_pkg::ST_GAIN;
         end
         biq_pkg::ST_GAIN: begin
            acc_in    = mac_sum;
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
            cnt_in    = cnt_ff + CNT_W'(1);
            if (last_bit) begin
               state_in = biq_pkg::ST_FIN;
            end
         end
         biq_pkg::ST_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               priority if (s_val > S_HI) begin
                  rsp_sample_in = SAMPLE_WIDTH'(S_HI);
                  rsp_clip_in   = 1'b1;
               end else if (s_val < S_LO) begin
                  rsp_sample_in = SAMPLE_WIDTH'(S_LO);
                  rsp_clip_in   = 1'b1;
               end else begin
                  rsp_sample_in = s_val[SAMPLE_WIDTH-1:0];
                  rsp_clip_in   = clip_ff;
               end
               state_in = biq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = biq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= biq_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         x1_ff        <= '0;
         x2_ff        <= '0;
         y1_ff        <= '0;
         y2_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == biq_pkg::ST_SAT) begin
            x2_ff <= x1_ff;
            x1_ff <= x_ff;
            y2_ff <= y1_ff;
            y1_ff <= y_val;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff   <= COEF_WIDTH'(16384);
         b1_ff   <= '0;
         b2_ff   <= '0;
         a0_ff   <= A0_W'(16384);
         a1_ff   <= '0;
         a2_ff   <= '0;
         gain_ff <= COEF_WIDTH'(16384);
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            biq_pkg::REG_B0:   b0_ff   <= csr_data;
            biq_pkg::REG_B1:   b1_ff   <= csr_data;
            biq_pkg::REG_B2:   b2_ff   <= csr_data;
            biq_pkg::REG_A0:   a0_ff   <= csr_data[A0_W-1:0];
            biq_pkg::REG_A1:   a1_ff   <= csr_data;
            biq_pkg::REG_A2:   a2_ff   <= csr_data;
            biq_pkg::REG_GAIN: gain_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         x_ff <= req_sample_in;
      end
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      cnt_ff        <= cnt_in;
      term_ff       <= term_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      zero_ff       <= zero_in;
      clip_ff       <= clip_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_clip_ff   <= rsp_clip_in;
   end

endmodule

[hw/rtl/biq_checker.sv]
// Port-level checks of the biquad IIR filter, and the bind that attaches them.
// Depends on the top level biquad_iir_filter.
module biq_checker #(
   parameter int SAMPLE_WIDTH = 16
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_ready,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out,
   input logic                           rsp_clipped
);

   // A waiting result stays offered, unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out) && $stable(rsp_clipped))
      else $error("result item changed or dropped while stalled");

   // Nothing is offered right after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // Once an item is taken, the block is busy with it in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while one is in work");

   // A new result appears only at the end of a computation, never from idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) && !$past(reset) |-> !$past(req_ready))
      else $error("result item appeared without a computation");

endmodule

bind biquad_iir_filter biq_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_biq_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_sample_out (rsp_sample_out),
   .rsp_clipped    (rsp_clipped)
);
